### hdl/u8d_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
// Used by the decode unit and by the top level; depends on nothing.
package u8d_pkg;

   // Fields of one input transaction.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_text;
   } req_data_type;

   // Fields of one result transaction.
   typedef struct packed {
      logic [20:0] code_point;
      logic        last_of_run;
      logic        string_done;
   } rsp_data_type;

   // Four byte window, entry 0 is the oldest byte.
   typedef logic [3:0][7:0] byte_window_type;

   // Verdict of the decode unit for the sequence at the window head.
   typedef struct packed {
      logic        hold_more;   // valid prefix, keep bytes until more arrive
      logic [2:0]  used;        // bytes consumed by this code point
      logic [20:0] code_point;  // decoded value or the replacement character
   } dec_result_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam logic [20:0] REPL_CHAR   = 21'h00FFFD;
   localparam logic [20:0] MAX_CP      = 21'h10FFFF;
   localparam logic [20:0] MIN_CP_FOUR = 21'h010000;
   localparam logic [20:0] MIN_CP_THREE = 21'h000800;
   localparam logic [20:0] MIN_CP_TWO  = 21'h000080;

endpackage

### hdl/u8d_decode.sv
// Decode unit: judges the UTF-8 sequence at the head of a four byte window.
// Depends on u8d_pkg for the window and verdict types.
module u8d_decode (
   input  u8d_pkg::byte_window_type window,
   input  logic [2:0]               avail,
   input  logic                     end_of_text,
   output u8d_pkg::dec_result_type  result
);
   import u8d_pkg::*;

   function automatic logic is_cont(input logic [7:0] b);
      is_cont = (b[7:6] == 2'b10);
   endfunction

   // Classify the lead byte, check continuations, assemble and range check.
   always_comb begin
      logic [7:0]  c0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      logic [2:0]  need;
      logic        bad;
      logic        ok;
      logic [20:0] value;

      c0 = window[0];
      b1 = window[1];
      b2 = window[2];
      b3 = window[3];

      // Sequence length implied by the lead byte; zero means it cannot lead.
      priority if (c0[7] == 1'b0) begin
         need = 3'd1;
      end else if (c0[7:5] == 3'b110) begin
         need = 3'd2;
      end else if (c0[7:4] == 4'b1110) begin
         need = 3'd3;
      end else if (c0[7:3] == 5'b11110) begin
         need = 3'd4;
      end else begin
         need = 3'd0;
      end

      // A byte present within the sequence that is not a continuation breaks it.
      bad = (need >= 3'd2 && avail >= 3'd2 && !is_cont(b1)) ||
            (need >= 3'd3 && avail >= 3'd3 && !is_cont(b2)) ||
            (need == 3'd4 && avail >= 3'd4 && !is_cont(b3));

      // Assemble the payload bits and reject overlong or out of range values.
      unique case (need)
         3'd2: begin
            value = {10'd0, c0[4:0], b1[5:0]};
            ok    = (value >= MIN_CP_TWO);
         end
         3'd3: begin
            value = {5'd0, c0[3:0], b1[5:0], b2[5:0]};
            ok    = (value >= MIN_CP_THREE);
         end
         3'd4: begin
            value = {c0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            ok    = (value >= MIN_CP_FOUR) && (value <= MAX_CP);
         end
         default: begin
            value = {13'd0, c0};
            ok    = 1'b1;
         end
      endcase

      result.hold_more  = 1'b0;
      result.used       = 3'd1;
      result.code_point = REPL_CHAR;
      if (need == 3'd1) begin
         result.code_point = {13'd0, c0};
      end else if (need != 3'd0) begin
         if (!bad && avail < need) begin
            result.hold_more = !end_of_text;
         end else if (!bad && ok) begin
            result.code_point = value;
            result.used       = need;
         end
      end
   end

endmodule

### hdl/utf8_to_code_point_decoder.sv
// Top level of the UTF-8 to code point decoder: byte window, sequencer and
// result register around the shared decode unit. Depends on u8d_pkg, u8d_decode.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_data_type (byte, end flag)
//   rsp_      out        rsp_valid / rsp_ready  rsp_data_type (code point, flags)
//
// A byte is taken while idle, then the decode unit runs once per cycle, unless the
// result channel stalls, over the byte window: once per code point produced plus
// one closing pass, with req_ready low until the window waits or empties.
// Results are staged one behind the decode unit so the last one can be flagged.
// Reset clears the sequencer, the byte count and the staged and result valid flags.
// A stalled result channel holds the sequencer while a staged result waits.
module utf8_to_code_point_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  u8d_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output u8d_pkg::rsp_data_type rsp_data
);
   import u8d_pkg::*;

   state_type       state_ff, state_in;
   byte_window_type window_ff, window_in;
   logic [2:0]      have_ff, have_in;
   logic            eot_ff, eot_in;
   logic            hold_valid_ff, hold_valid_in;
   logic [20:0]     hold_cp_ff, hold_cp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_data_type    rsp_data_ff, rsp_data_in;
   dec_result_type  dec;
   logic            finish;
   logic            out_free;
   logic            stall;

   // Shared decode unit, looking at the head of the window.
   u8d_decode u_decode (
      .window      (window_ff),
      .avail       (have_ff),
      .end_of_text (eot_ff),
      .result      (dec)
   );

   assign finish    = (have_ff == 3'd0) || dec.hold_more;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stall     = hold_valid_ff && !out_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: append a byte, then decode and shift until the window waits or empties.
   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      have_in       = have_ff;
      eot_in        = eot_ff;
      hold_valid_in = hold_valid_ff;
      hold_cp_in    = hold_cp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               window_in[have_ff[1:0]] = req_data.byte_value;
               have_in  = have_ff + 3'd1;
               eot_in   = req_data.end_of_text;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               // The staged result leaves; it is the last one if nothing follows.
               if (hold_valid_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.code_point  = hold_cp_ff;
                  rsp_data_in.last_of_run = finish;
                  rsp_data_in.string_done = finish && eot_ff;
               end
               if (finish) begin
                  hold_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  hold_valid_in = 1'b1;
                  hold_cp_in    = dec.code_point;
                  have_in       = have_ff - dec.used;
                  // Drop the consumed bytes from the head of the window.
                  unique case (dec.used)
                     3'd1:    window_in = window_ff >> 8;
                     3'd2:    window_in = window_ff >> 16;
                     3'd3:    window_in = window_ff >> 24;
                     default: window_in = window_ff;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_ff       <= 3'd0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_ff       <= have_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      eot_ff      <= eot_in;
      hold_cp_ff  <= hold_cp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // At most three bytes stay pending between transactions.
   a_pending_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> have_ff <= 3'd3)
      else $error("pending byte count exceeds three while idle");

   // A string end flushes every buffered byte.
   a_flush_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_SCAN && eot_ff) |-> have_ff == 3'd0)
      else $error("bytes left pending after end of text");

   // The decode unit never consumes bytes that are not in the window.
   a_used_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !finish) |-> (dec.used <= have_ff && dec.used != 3'd0))
      else $error("decode consumed more bytes than buffered");

   // A staged result survives a stall of the result channel.
   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stall) |=> (hold_valid_ff && $stable(hold_cp_ff)))
      else $error("staged result lost during stall");

   // String completion is only flagged on the final result of a transaction.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.string_done) |-> rsp_data_ff.last_of_run)
      else $error("string_done without last_of_run");

endmodule
